// ===== sv/ffa_pkg.sv =====
// Package for the forest fire automaton: cell and command codes, register
// indexes, reset values, the state type and the LFSR step function.
// Depends on nothing; the top level, the checker and the testbench use it.
`default_nettype none

package ffa_pkg;

    localparam int PROB_W     = 16;
    localparam int LFSR_W     = 32;
    localparam int COUNT_W    = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_TREE  = 2'd1;
    localparam logic [1:0] CELL_FIRE  = 2'd2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;
    localparam logic [1:0] KIND_STEP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 4'd3;

    localparam logic [PROB_W-1:0]  GROWTH_RESET   = 16'd5374;
    localparam logic [PROB_W-1:0]  DENSITY_RESET  = 16'd39322;
    localparam logic [PROB_W-1:0]  FRACTION_RESET = 16'd6554;
    localparam logic [LFSR_W-1:0]  LFSR_RESET     = 32'd1;
    localparam logic [LFSR_W-1:0]  LFSR_TAPS      = 32'hA300_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 13'd8191;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WB,
        ST_FILL,
        ST_ADV,
        ST_DONE
    } t_state;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ffa_in_if.sv =====
// Command channel of the forest fire automaton: valid, ready and one word.
// Depends on nothing.
`default_nettype none

interface ffa_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [5:0] row;
    logic [5:0] col;
    logic [1:0] cell_value;

    modport source (output valid, kind, row, col, cell_value, input ready);
    modport sink   (input valid, kind, row, col, cell_value, output ready);
endinterface

`default_nettype wire

// ===== sv/ffa_out_if.sv =====
// Result channel of the forest fire automaton: valid, ready and one word.
// Depends on nothing.
`default_nettype none

interface ffa_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  read_value;
    logic [12:0] fire_count;
    logic        finished;

    modport source (output valid, read_value, fire_count, finished, input ready);
    modport sink   (input valid, read_value, fire_count, finished, output ready);
endinterface

`default_nettype wire

// ===== sv/ffa_cell_mem.sv =====
// Cell memory of the forest fire automaton: one write port, two read ports,
// read data registered. Depends on nothing.
`default_nettype none

module ffa_cell_mem #(
    parameter int AW = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [1:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr_a,
    output logic [1:0]         o_rdata_a,
    input  wire logic [AW-1:0] i_raddr_b,
    output logic [1:0]         o_rdata_b
);

    logic [1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== sv/forest_fire_automaton_top.sv =====
// Forest fire automaton top level: command decode, fill and generation
// sequencer over the cell memory. Depends on ffa_pkg, ffa_in_if,
// ffa_out_if and ffa_cell_mem.
//
// The grid of SIDE by SIDE cells lives in one memory holding two banks; a
// generation reads the current bank and writes the other, then the banks
// swap. The single write port of that memory sets the pace at one cell per
// cycle. A random fill writes every cell of the grid, and a generation
// streams one extra row before and after the grid to cover the wrap of the
// torus; a generation on a grid without fire skips that pass. After reset
// the block clears the grid and accepts no word meanwhile; configuration
// writes are taken at any time. A result word waiting on the output does
// not stop the block from taking the next command.
`default_nettype none

module forest_fire_automaton_top #(
    parameter int SIDE = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ffa_in_if.sink                              i_in,
    ffa_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [ffa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ffa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CELLS  = SIDE * SIDE;
    localparam int LW     = $clog2(CELLS);
    localparam int AW     = LW + 1;
    localparam int CW     = $clog2(SIDE);
    localparam int NW     = ($clog2(CELLS + 1) > ffa_pkg::COUNT_W) ?
                            $clog2(CELLS + 1) : ffa_pkg::COUNT_W;
    localparam int STREAM = (SIDE + 2) * SIDE;
    localparam int SW     = $clog2(STREAM + 1);
    localparam int SHL    = 2 * SIDE + 1;

    localparam logic [LW-1:0] LAST_CELL   = LW'(CELLS - 1);
    localparam logic [LW-1:0] STREAM_BASE = LW'(CELLS - SIDE);
    localparam logic [SW-1:0] STREAM_LAST = SW'(STREAM - 1);
    localparam logic [SW-1:0] CENTER_OFS  = SW'(2 * SIDE);
    localparam logic [CW-1:0] LAST_COL    = CW'(SIDE - 1);

    ffa_pkg::t_state r_state, n_state;

    logic                          r_bank;
    logic [LW-1:0]                 r_la;
    logic [SW-1:0]                 r_cnt;
    logic                          r_issue;
    logic                          r_p1_valid;
    logic                          r_p1_center;
    logic                          r_p2_valid;
    logic [LW-1:0]                 r_p2_addr;
    logic [CW-1:0]                 r_p2_col;
    logic [LW-1:0]                 r_ca;
    logic [CW-1:0]                 r_ccol;
    logic [SHL-1:0]                r_sh;
    logic [NW-1:0]                 r_fire;
    logic [NW-1:0]                 r_acc;
    logic [ffa_pkg::LFSR_W-1:0]    r_lfsr;
    logic [ffa_pkg::PROB_W-1:0]    r_growth;
    logic [ffa_pkg::PROB_W-1:0]    r_density;
    logic [ffa_pkg::PROB_W-1:0]    r_fraction;
    logic [1:0]                    r_op_kind;
    logic [LW-1:0]                 r_op_addr;
    logic                          r_op_inside;
    logic [1:0]                    r_op_val;
    logic [1:0]                    r_res_read;
    logic                          r_res_fin;
    logic                          r_out_valid;
    logic [1:0]                    r_out_read;
    logic [ffa_pkg::COUNT_W-1:0]   r_out_count;
    logic                          r_out_fin;

    logic                          accept;
    logic                          can_emit;
    logic                          in_inside;
    logic [LW-1:0]                 in_addr;
    logic [1:0]                    in_val;
    logic [1:0]                    rd_a;
    logic [1:0]                    rd_b;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [1:0]                    mem_wdata;
    logic [AW-1:0]                 mem_raddr_a;
    logic [LW-1:0]                 la_inc;
    logic [ffa_pkg::LFSR_W-1:0]    fill_d1;
    logic [ffa_pkg::LFSR_W-1:0]    fill_d2;
    logic                          fill_occ;
    logic                          fill_burn;
    logic [1:0]                    fill_val;
    logic [ffa_pkg::LFSR_W-1:0]    grow_d;
    logic                          grow_hit;
    logic                          nb_fire;
    logic                          nb_left;
    logic                          nb_right;
    logic [1:0]                    adv_val;
    logic                          adv_burn;
    logic                          adv_draw;
    logic                          adv_last;
    logic                          old_burn;
    logic                          new_burn;

    assign accept   = i_in.valid && i_in.ready;
    assign can_emit = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ffa_pkg::ST_IDLE);

    assign in_inside = (32'(i_in.row) < SIDE) && (32'(i_in.col) < SIDE);
    assign in_addr   = LW'(32'(i_in.row) * 32'(SIDE) + 32'(i_in.col));
    assign in_val    = (i_in.cell_value == 2'd3) ? ffa_pkg::CELL_EMPTY : i_in.cell_value;

    assign la_inc = (r_la == LAST_CELL) ? '0 : r_la + 1'b1;

    assign fill_d1   = ffa_pkg::lfsr_step(r_lfsr);
    assign fill_d2   = ffa_pkg::lfsr_step(fill_d1);
    assign fill_occ  = fill_d1[31:16] < r_density;
    assign fill_burn = fill_occ && (fill_d2[31:16] < r_fraction);
    assign fill_val  = !fill_occ ? ffa_pkg::CELL_EMPTY :
                       (fill_burn ? ffa_pkg::CELL_FIRE : ffa_pkg::CELL_TREE);

    assign grow_d   = ffa_pkg::lfsr_step(r_lfsr);
    assign grow_hit = grow_d[31:16] < r_growth;

    assign nb_left  = (r_p2_col == '0) ? r_sh[1] : r_sh[SIDE+1];
    assign nb_right = (r_p2_col == LAST_COL) ? r_sh[2*SIDE-1] : r_sh[SIDE-1];
    assign nb_fire  = r_sh[2*SIDE] || r_sh[0] || nb_left || nb_right;

    always_comb begin
        adv_val  = rd_b;
        adv_draw = 1'b0;
        if (rd_b == ffa_pkg::CELL_FIRE) begin
            adv_val = ffa_pkg::CELL_EMPTY;
        end else if (rd_b == ffa_pkg::CELL_TREE) begin
            if (nb_fire) begin
                adv_val = ffa_pkg::CELL_FIRE;
            end
        end else if (rd_b == ffa_pkg::CELL_EMPTY) begin
            adv_draw = 1'b1;
            if (grow_hit) begin
                adv_val = ffa_pkg::CELL_TREE;
            end
        end
    end

    assign adv_burn = r_p2_valid && (adv_val == ffa_pkg::CELL_FIRE);
    assign adv_last = r_p2_valid && (r_p2_addr == LAST_CELL);
    assign old_burn = (rd_a == ffa_pkg::CELL_FIRE);
    assign new_burn = (r_op_val == ffa_pkg::CELL_FIRE);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_bank, r_la};
        mem_wdata = ffa_pkg::CELL_EMPTY;
        if (r_state == ffa_pkg::ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == ffa_pkg::ST_FILL) begin
            mem_we    = 1'b1;
            mem_wdata = fill_val;
        end else if (r_state == ffa_pkg::ST_WB) begin
            mem_we    = (r_op_kind == ffa_pkg::KIND_WRITE) && r_op_inside;
            mem_waddr = {r_bank, r_op_addr};
            mem_wdata = r_op_val;
        end else if (r_p2_valid) begin
            mem_we    = 1'b1;
            mem_waddr = {!r_bank, r_p2_addr};
            mem_wdata = adv_val;
        end
    end

    assign mem_raddr_a = (r_state == ffa_pkg::ST_ADV) ? {r_bank, r_la} : {r_bank, r_op_addr};

    ffa_cell_mem #(
        .AW (AW)
    ) u_ffa_cell_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .o_rdata_a (rd_a),
        .i_raddr_b ({r_bank, r_ca}),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffa_pkg::ST_CLEAR: begin
                if (r_la == LAST_CELL) begin
                    n_state = ffa_pkg::ST_IDLE;
                end
            end
            ffa_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_in.kind)
                        ffa_pkg::KIND_WRITE: n_state = ffa_pkg::ST_RD;
                        ffa_pkg::KIND_READ:  n_state = ffa_pkg::ST_RD;
                        ffa_pkg::KIND_FILL:  n_state = ffa_pkg::ST_FILL;
                        ffa_pkg::KIND_STEP: begin
                            n_state = (r_fire == '0) ? ffa_pkg::ST_DONE : ffa_pkg::ST_ADV;
                        end
                        default: n_state = ffa_pkg::ST_IDLE;
                    endcase
                end
            end
            ffa_pkg::ST_RD: n_state = ffa_pkg::ST_WB;
            ffa_pkg::ST_WB: n_state = ffa_pkg::ST_DONE;
            ffa_pkg::ST_FILL: begin
                if (r_la == LAST_CELL) begin
                    n_state = ffa_pkg::ST_DONE;
                end
            end
            ffa_pkg::ST_ADV: begin
                if (adv_last) begin
                    n_state = ffa_pkg::ST_DONE;
                end
            end
            ffa_pkg::ST_DONE: begin
                if (can_emit) begin
                    n_state = ffa_pkg::ST_IDLE;
                end
            end
            default: n_state = ffa_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank      <= 1'b0;
            r_la        <= '0;
            r_cnt       <= '0;
            r_issue     <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_p1_center <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_ca        <= '0;
            r_ccol      <= '0;
            r_fire      <= '0;
            r_acc       <= '0;
            r_lfsr      <= ffa_pkg::LFSR_RESET;
            r_growth    <= ffa_pkg::GROWTH_RESET;
            r_density   <= ffa_pkg::DENSITY_RESET;
            r_fraction  <= ffa_pkg::FRACTION_RESET;
            r_op_kind   <= ffa_pkg::KIND_READ;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ffa_pkg::ST_CLEAR || r_state == ffa_pkg::ST_FILL) begin
                r_la <= la_inc;
            end else if (r_state == ffa_pkg::ST_IDLE) begin
                r_la <= (i_in.kind == ffa_pkg::KIND_STEP) ? STREAM_BASE : '0;
            end else if (r_state == ffa_pkg::ST_ADV && r_issue) begin
                r_la <= la_inc;
            end

            if (accept) begin
                r_op_kind <= i_in.kind;
                r_acc     <= '0;
                r_cnt     <= '0;
                r_ca      <= '0;
                r_ccol    <= '0;
                r_issue   <= (i_in.kind == ffa_pkg::KIND_STEP) && (r_fire != '0);
            end else if (r_state == ffa_pkg::ST_ADV && r_issue) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STREAM_LAST) begin
                    r_issue <= 1'b0;
                end
            end

            r_p1_valid  <= (r_state == ffa_pkg::ST_ADV) && r_issue;
            r_p1_center <= r_cnt >= CENTER_OFS;

            if (r_p1_valid && r_p1_center) begin
                r_p2_valid <= 1'b1;
                r_ca       <= r_ca + 1'b1;
                r_ccol     <= (r_ccol == LAST_COL) ? '0 : r_ccol + 1'b1;
            end else begin
                r_p2_valid <= 1'b0;
            end

            if (r_state == ffa_pkg::ST_FILL) begin
                r_acc <= r_acc + NW'(fill_burn);
                if (r_la == LAST_CELL) begin
                    r_fire <= r_acc + NW'(fill_burn);
                end
            end else if (r_p2_valid) begin
                r_acc <= r_acc + NW'(adv_burn);
                if (adv_last) begin
                    r_fire <= r_acc + NW'(adv_burn);
                    r_bank <= !r_bank;
                end
            end else if (r_state == ffa_pkg::ST_WB && r_op_kind == ffa_pkg::KIND_WRITE &&
                         r_op_inside) begin
                r_fire <= r_fire - NW'(old_burn) + NW'(new_burn);
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ffa_pkg::CFG_GROWTH:   r_growth   <= i_cfg_data[15:0];
                    ffa_pkg::CFG_DENSITY:  r_density  <= i_cfg_data[15:0];
                    ffa_pkg::CFG_FRACTION: r_fraction <= i_cfg_data[15:0];
                    ffa_pkg::CFG_SEED: begin
                        r_lfsr <= (i_cfg_data == '0) ? ffa_pkg::LFSR_RESET : i_cfg_data;
                    end
                    default: ;
                endcase
            end else if (r_state == ffa_pkg::ST_FILL) begin
                r_lfsr <= fill_occ ? fill_d2 : fill_d1;
            end else if (r_p2_valid && adv_draw) begin
                r_lfsr <= grow_d;
            end

            if (r_state == ffa_pkg::ST_DONE && can_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op_addr   <= in_addr;
            r_op_inside <= in_inside;
            r_op_val    <= in_val;
            r_res_read  <= ffa_pkg::CELL_EMPTY;
            r_res_fin   <= (i_in.kind == ffa_pkg::KIND_STEP) && (r_fire == '0);
        end else if (r_state == ffa_pkg::ST_WB && r_op_kind == ffa_pkg::KIND_READ &&
                     r_op_inside) begin
            r_res_read <= rd_a;
        end

        if (r_p1_valid) begin
            r_sh <= {r_sh[SHL-2:0], rd_a == ffa_pkg::CELL_FIRE};
        end
        if (r_p1_valid && r_p1_center) begin
            r_p2_addr <= r_ca;
            r_p2_col  <= r_ccol;
        end

        if (r_state == ffa_pkg::ST_DONE && can_emit) begin
            r_out_read  <= r_res_read;
            r_out_fin   <= r_res_fin;
            r_out_count <= (r_fire > NW'(ffa_pkg::COUNT_MAX)) ?
                           ffa_pkg::COUNT_MAX : r_fire[ffa_pkg::COUNT_W-1:0];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_out_read;
    assign o_out.fire_count = r_out_count;
    assign o_out.finished   = r_out_fin;

endmodule

`default_nettype wire

// ===== sv/ffa_checker.sv =====
// Port-level checks for the forest fire automaton and the bind that
// attaches them to the top level. Depends on ffa_pkg and the top level.
`default_nettype none

module ffa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_out_read_value,
    input wire logic [12:0] i_out_fire_count,
    input wire logic        i_out_finished
);

    // The grid is cleared after every reset, so no word is taken right after it.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("command taken during the clearing pass");

    // A generation that did nothing can only have seen a grid without fire.
    a_finished_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_finished |->
            i_out_fire_count == 13'd0 && i_out_read_value == ffa_pkg::CELL_EMPTY)
        else $error("finished reported with fire in the grid");

    a_read_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_read_value <= ffa_pkg::CELL_FIRE)
        else $error("read returned an invalid cell code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_read_value) && $stable(i_out_fire_count) &&
            $stable(i_out_finished))
        else $error("result word changed while stalled");

endmodule

bind forest_fire_automaton_top ffa_checker u_ffa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_read_value (o_out.read_value),
    .i_out_fire_count (o_out.fire_count),
    .i_out_finished   (o_out.finished)
);

`default_nettype wire

// ===== tb/sv/forest_fire_automaton_top_tb.sv =====
// Self-checking testbench for forest_fire_automaton_top: a directed table, then random
// fill and burn episodes, with results checked against an in-bench grid predictor.
// Depends on ffa_pkg, ffa_in_if, ffa_out_if and the block's RTL.
`default_nettype none

module forest_fire_automaton_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    localparam int GRID_SIDE      = 64;
    localparam int GRID_CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int RANDOM_ITEMS   = 140;
    localparam int PHASE_ITEMS    = 30;
    localparam int TAIL_CYCLES    = (GRID_SIDE + 2) * GRID_SIDE + 8;
    localparam int CYCLE_LIMIT    = 3_000_000;

    localparam logic [1:0]           CELL_BAD   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd12;

    typedef struct packed {
        logic [1:0]         read_value;
        logic [COUNT_W-1:0] fire_count;
        logic               finished;
    } fire_result_t;

    typedef enum logic {
        DO_ITEM,
        DO_CFG
    } row_op_t;

    typedef struct packed {
        row_op_t                op;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic [CFG_DATA_W-1:0]  cfg_data;
        logic [1:0]             kind;
        logic [5:0]             row;
        logic [5:0]             col;
        logic [1:0]             value;
        logic                   typed;
        fire_result_t           want;
    } plan_row_t;

    localparam fire_result_t ANY = '0;
    localparam int DIRECTED_ROWS = 31;
    localparam plan_row_t DIRECTED_PLAN [DIRECTED_ROWS] = '{
        '{DO_ITEM, '0, '0, KIND_READ,  6'd0,  6'd0,  CELL_EMPTY, 1'b1, '{CELL_EMPTY, 13'd0, 1'b0}},
        '{DO_ITEM, '0, '0, KIND_STEP,  6'd0,  6'd0,  CELL_EMPTY, 1'b1, '{CELL_EMPTY, 13'd0, 1'b1}},
        '{DO_ITEM, '0, '0, KIND_WRITE, 6'd63, 6'd63, CELL_FIRE,  1'b1, '{CELL_EMPTY, 13'd1, 1'b0}},
        '{DO_ITEM, '0, '0, KIND_READ,  6'd63, 6'd63, CELL_EMPTY, 1'b1, '{CELL_FIRE,  13'd1, 1'b0}},
        '{DO_ITEM, '0, '0, KIND_WRITE, 6'd0,  6'd63, CELL_TREE,  1'b1, '{CELL_EMPTY, 13'd1, 1'b0}},
        '{DO_ITEM, '0, '0, KIND_WRITE, 6'd63, 6'd0,  CELL_TREE,  1'b1, '{CELL_EMPTY, 13'd1, 1'b0}},
        '{DO_ITEM, '0, '0, KIND_WRITE, 6'd0,  6'd0,  CELL_TREE,  1'b1, '{CELL_EMPTY, 13'd1, 1'b0}},
        '{DO_ITEM, '0, '0, KIND_WRITE, 6'd31, 6'd17, CELL_BAD,   1'b1, '{CELL_EMPTY, 13'd1, 1'b0}},
        '{DO_ITEM, '0, '0, KIND_READ,  6'd31, 6'd17, CELL_EMPTY, 1'b1, '{CELL_EMPTY, 13'd1, 1'b0}},
        '{DO_CFG,  CFG_GROWTH,   32'd0,   '0, '0, '0, '0, 1'b0, ANY},
        '{DO_ITEM, '0, '0, KIND_STEP,  6'd0,  6'd0,  CELL_EMPTY, 1'b0, ANY},
        '{DO_ITEM, '0, '0, KIND_READ,  6'd0,  6'd63, CELL_EMPTY, 1'b0, ANY},
        '{DO_ITEM, '0, '0, KIND_STEP,  6'd0,  6'd0,  CELL_EMPTY, 1'b0, ANY},
        '{DO_ITEM, '0, '0, KIND_READ,  6'd0,  6'd0,  CELL_EMPTY, 1'b0, ANY},
        '{DO_CFG,  CFG_DENSITY,  32'hFFFF, '0, '0, '0, '0, 1'b0, ANY},
        '{DO_CFG,  CFG_FRACTION, 32'd0,   '0, '0, '0, '0, 1'b0, ANY},
        '{DO_ITEM, '0, '0, KIND_FILL,  6'd0,  6'd0,  CELL_EMPTY, 1'b1, '{CELL_EMPTY, 13'd0, 1'b0}},
        '{DO_ITEM, '0, '0, KIND_STEP,  6'd0,  6'd0,  CELL_EMPTY, 1'b1, '{CELL_EMPTY, 13'd0, 1'b1}},
        '{DO_CFG,  CFG_SEED,     32'd0,   '0, '0, '0, '0, 1'b0, ANY},
        '{DO_CFG,  CFG_FRACTION, 32'hFFFF, '0, '0, '0, '0, 1'b0, ANY},
        '{DO_ITEM, '0, '0, KIND_FILL,  6'd0,  6'd0,  CELL_EMPTY, 1'b0, ANY},
        '{DO_ITEM, '0, '0, KIND_STEP,  6'd0,  6'd0,  CELL_EMPTY, 1'b0, ANY},
        '{DO_CFG,  CFG_DENSITY,  32'd0,   '0, '0, '0, '0, 1'b0, ANY},
        '{DO_ITEM, '0, '0, KIND_FILL,  6'd0,  6'd0,  CELL_EMPTY, 1'b1, '{CELL_EMPTY, 13'd0, 1'b0}},
        '{DO_CFG,  CFG_SEED,     32'hFFFF_FFFF, '0, '0, '0, '0, 1'b0, ANY},
        '{DO_CFG,  CFG_GROWTH,   32'hFFFF, '0, '0, '0, '0, 1'b0, ANY},
        '{DO_CFG,  CFG_UNUSED,   32'd0,   '0, '0, '0, '0, 1'b0, ANY},
        '{DO_ITEM, '0, '0, KIND_WRITE, 6'd10, 6'd10, CELL_FIRE,  1'b1, '{CELL_EMPTY, 13'd1, 1'b0}},
        '{DO_ITEM, '0, '0, KIND_WRITE, 6'd10, 6'd11, CELL_TREE,  1'b1, '{CELL_EMPTY, 13'd1, 1'b0}},
        '{DO_ITEM, '0, '0, KIND_STEP,  6'd0,  6'd0,  CELL_EMPTY, 1'b0, ANY},
        '{DO_ITEM, '0, '0, KIND_READ,  6'd10, 6'd11, CELL_EMPTY, 1'b0, ANY}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ffa_in_if  cmd_if ();
    ffa_out_if res_if ();

    forest_fire_automaton_top #(
        .SIDE(GRID_SIDE)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (cmd_if),
        .o_out     (res_if),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    logic [1:0]         fire_grid [GRID_CELLS];
    logic [1:0]         grid_next [GRID_CELLS];
    logic [LFSR_W-1:0]  grid_lfsr;
    logic [COUNT_W-1:0] grid_burning;
    logic [PROB_W-1:0]  prob_growth;
    logic [PROB_W-1:0]  prob_density;
    logic [PROB_W-1:0]  prob_fraction;

    fire_result_t awaited_results [$];
    fire_result_t want;
    bit           steady;
    int           failures;
    int           results_checked;
    int           burnt_out_seen;
    int           peak_fire;
    int           commands_sent;
    int           kind_seen [4];
    longint       cycles;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $error("run exceeded %0d cycles", CYCLE_LIMIT);
            $display("forest_fire_automaton_top verification failed");
            $finish;
        end
    end

    function automatic bit lfsr_draw(logic [PROB_W-1:0] prob);
        logic lsb;
        lsb = grid_lfsr[0];
        grid_lfsr = grid_lfsr >> 1;
        if (lsb) begin
            grid_lfsr = grid_lfsr ^ LFSR_TAPS;
        end
        return grid_lfsr[LFSR_W-1:16] < prob;
    endfunction

    function automatic logic [COUNT_W-1:0] count_burning();
        int n;
        n = 0;
        for (int k = 0; k < GRID_CELLS; k++) begin
            if (fire_grid[k] == CELL_FIRE) begin
                n++;
            end
        end
        return (n > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(n);
    endfunction

    function automatic fire_result_t forecast_result(logic [1:0] kind, logic [5:0] row,
                                                     logic [5:0] col, logic [1:0] value);
        fire_result_t res;
        bit           on_grid;
        int           up, dn, lf, rt, k;
        logic [1:0]   nv;
        res = '0;
        on_grid = (int'(row) < GRID_SIDE) && (int'(col) < GRID_SIDE);
        k = int'(row) * GRID_SIDE + int'(col);
        case (kind)
            KIND_WRITE: begin
                if (on_grid) begin
                    fire_grid[k] = (value == CELL_BAD) ? CELL_EMPTY : value;
                end
                grid_burning = count_burning();
            end
            KIND_READ: begin
                if (on_grid) begin
                    res.read_value = fire_grid[k];
                end
            end
            KIND_FILL: begin
                for (int j = 0; j < GRID_CELLS; j++) begin
                    if (lfsr_draw(prob_density)) begin
                        fire_grid[j] = lfsr_draw(prob_fraction) ? CELL_FIRE : CELL_TREE;
                    end else begin
                        fire_grid[j] = CELL_EMPTY;
                    end
                end
                grid_burning = count_burning();
            end
            KIND_STEP: begin
                grid_burning = count_burning();
                if (grid_burning == 0) begin
                    res.finished = 1'b1;
                end else begin
                    for (int r = 0; r < GRID_SIDE; r++) begin
                        up = (r + GRID_SIDE - 1) % GRID_SIDE;
                        dn = (r + 1) % GRID_SIDE;
                        for (int c = 0; c < GRID_SIDE; c++) begin
                            lf = (c + GRID_SIDE - 1) % GRID_SIDE;
                            rt = (c + 1) % GRID_SIDE;
                            nv = fire_grid[r * GRID_SIDE + c];
                            if (nv == CELL_FIRE) begin
                                nv = CELL_EMPTY;
                            end else if (nv == CELL_TREE) begin
                                if (fire_grid[up * GRID_SIDE + c] == CELL_FIRE ||
                                    fire_grid[dn * GRID_SIDE + c] == CELL_FIRE ||
                                    fire_grid[r * GRID_SIDE + lf] == CELL_FIRE ||
                                    fire_grid[r * GRID_SIDE + rt] == CELL_FIRE) begin
                                    nv = CELL_FIRE;
                                end
                            end else if (lfsr_draw(prob_growth)) begin
                                nv = CELL_TREE;
                            end
                            grid_next[r * GRID_SIDE + c] = nv;
                        end
                    end
                    fire_grid = grid_next;
                    grid_burning = count_burning();
                end
            end
            default: ;
        endcase
        res.fire_count = grid_burning;
        return res;
    endfunction

    function automatic logic [PROB_W-1:0] pick_prob();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            default: return PROB_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cmd_if.valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_GROWTH:   prob_growth   = data[PROB_W-1:0];
            CFG_DENSITY:  prob_density  = data[PROB_W-1:0];
            CFG_FRACTION: prob_fraction = data[PROB_W-1:0];
            CFG_SEED:     grid_lfsr     = (data == '0) ? LFSR_RESET : data;
            default: ;
        endcase
    endtask

    task automatic send_command(logic [1:0] kind, logic [5:0] row, logic [5:0] col,
                                logic [1:0] value, logic typed, fire_result_t typed_want);
        fire_result_t guess;
        i_cfg_we <= 1'b0;
        while (!steady && $urandom_range(0, 99) < 9) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.kind       <= kind;
        cmd_if.row        <= row;
        cmd_if.col        <= col;
        cmd_if.cell_value <= value;
        do begin
            @(posedge i_clk);
        end while (!cmd_if.ready);
        guess = forecast_result(kind, row, col, value);
        awaited_results.push_back(typed ? typed_want : guess);
        commands_sent++;
        kind_seen[kind]++;
    endtask

    task automatic send_random(logic [1:0] kind);
        send_command(kind, 6'($urandom), 6'($urandom), 2'($urandom), 1'b0, ANY);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with no command outstanding");
                    failures++;
                end else begin
                    want = awaited_results.pop_front();
                    if (res_if.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, actual %0d",
                               want.read_value, res_if.read_value);
                        failures++;
                    end
                    if (res_if.fire_count !== want.fire_count) begin
                        $error("fire_count: expected %0d, actual %0d",
                               want.fire_count, res_if.fire_count);
                        failures++;
                    end
                    if (res_if.finished !== want.finished) begin
                        $error("finished: expected %0d, actual %0d",
                               want.finished, res_if.finished);
                        failures++;
                    end
                    results_checked++;
                    if (want.finished) begin
                        burnt_out_seen++;
                    end
                    if (int'(res_if.fire_count) > peak_fire) begin
                        peak_fire = int'(res_if.fire_count);
                    end
                end
            end
            res_if.ready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    initial begin
        int        directed_items;
        int        next_phase_at;
        int        phase_no;
        int        steps;
        int        pokes;
        plan_row_t p;

        cmd_if.valid      <= 1'b0;
        cmd_if.kind       <= KIND_WRITE;
        cmd_if.row        <= '0;
        cmd_if.col        <= '0;
        cmd_if.cell_value <= CELL_EMPTY;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_GROWTH;
        i_cfg_data        <= '0;
        i_rst_n           <= 1'b0;
        steady            = 1'b0;
        failures          = 0;
        results_checked   = 0;
        burnt_out_seen    = 0;
        peak_fire         = 0;
        commands_sent     = 0;
        cycles            = 0;
        for (int k = 0; k < 4; k++) begin
            kind_seen[k] = 0;
        end
        for (int k = 0; k < GRID_CELLS; k++) begin
            fire_grid[k] = CELL_EMPTY;
        end
        grid_lfsr     = LFSR_RESET;
        grid_burning  = '0;
        prob_growth   = GROWTH_RESET;
        prob_density  = DENSITY_RESET;
        prob_fraction = FRACTION_RESET;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            p = DIRECTED_PLAN[i];
            if (p.op == DO_CFG) begin
                write_register(p.cfg_idx, p.cfg_data);
            end else begin
                send_command(p.kind, p.row, p.col, p.value, p.typed, p.want);
            end
        end
        directed_items = commands_sent;

        // Most of the random part fills the grid and lets fire run for a few
        // generations, with cell pokes in between; the rest is loose commands.
        next_phase_at = 0;
        phase_no = 0;
        while (commands_sent - directed_items < RANDOM_ITEMS) begin
            if (commands_sent - directed_items >= next_phase_at) begin
                write_register(CFG_GROWTH, CFG_DATA_W'(pick_prob()));
                write_register(CFG_DENSITY, CFG_DATA_W'(pick_prob()));
                write_register(CFG_FRACTION, CFG_DATA_W'(pick_prob()));
                case ($urandom_range(0, 3))
                    0: write_register(CFG_SEED, '0);
                    1: write_register(CFG_SEED, '1);
                    default: write_register(CFG_SEED, $urandom);
                endcase
                if ($urandom_range(0, 1) == 1) begin
                    write_register(CFG_IDX_W'($urandom_range(int'(CFG_SEED) + 1, 15)),
                                   $urandom);
                end
                steady = (phase_no == 2);
                next_phase_at += PHASE_ITEMS;
                phase_no++;
            end
            if ($urandom_range(0, 99) < 55) begin
                send_random(KIND_FILL);
                steps = $urandom_range(2, 6);
                for (int s = 0; s < steps; s++) begin
                    send_random(KIND_STEP);
                    pokes = $urandom_range(0, 2);
                    for (int q = 0; q < pokes; q++) begin
                        send_random(($urandom_range(0, 1) == 1) ? KIND_WRITE : KIND_READ);
                    end
                end
            end else begin
                send_random(2'($urandom_range(0, 3)));
            end
        end

        cmd_if.valid <= 1'b0;
        i_cfg_we     <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands: %0d writes, %0d reads, %0d fills, %0d generations.",
                 commands_sent, kind_seen[KIND_WRITE], kind_seen[KIND_READ],
                 kind_seen[KIND_FILL], kind_seen[KIND_STEP]);
        $display("Checked %0d results, %0d on a fire-free grid, peak of %0d burning cells.",
                 results_checked, burnt_out_seen, peak_fire);
        if (failures == 0) begin
            $display("forest_fire_automaton_top verification clean");
        end else begin
            $display("forest_fire_automaton_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
